// File: rtl/lbp_pkg.sv
// Shared types and constants for the LSB-first bit packer.
`timescale 1ns / 1ps

package lbp_pkg;

    localparam int MAX_CODE_BITS = 16;
    localparam int OFFSET_BITS   = 16;
    localparam int ACC_BITS      = 24;
    localparam int PEND_W        = 5;
    localparam int WIDTH_W       = 5;
    localparam int LIMIT_W       = OFFSET_BITS + 1;
    localparam int CFG_IDX_W     = 2;
    localparam int QDEPTH        = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_CAP   = LIMIT_W'(1) << OFFSET_BITS;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_CAP;

    typedef enum logic [1:0] {
        CMD_PUT     = 2'd0,
        CMD_FLUSH   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_UNDEF   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_OFFSET = CFG_IDX_W'(0),
        REG_OUT_LIMIT    = CFG_IDX_W'(1)
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_SECOND = 1'b1
    } back_state_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic                     width_err;
        logic [WIDTH_W-1:0]       width;
        logic [MAX_CODE_BITS-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0]             out_byte;
        logic [OFFSET_BITS-1:0] out_index;
        logic                   byte_valid;
        logic                   error;
        logic                   last;
    } result_t;

endpackage

// File: rtl/lbp_front.sv
// Front end: accepts input beats, masks the code and flags oversized widths.
`timescale 1ns / 1ps

module lbp_front (
    input  logic                                 push,
    input  logic [1:0]                           command,
    input  logic [lbp_pkg::MAX_CODE_BITS-1:0]    code_value,
    input  logic [lbp_pkg::WIDTH_W-1:0]          bit_width,
    input  logic                                 q_full,
    output logic                                 q_push,
    output lbp_pkg::cmd_item_t                   q_item
);

    logic [lbp_pkg::MAX_CODE_BITS-1:0] mask_wide;

    // a shift of 16 or more clears the one, so the mask wraps to all ones
    assign mask_wide = (lbp_pkg::MAX_CODE_BITS'(1) << bit_width) - lbp_pkg::MAX_CODE_BITS'(1);

    assign q_push = push && !q_full;

    always_comb
    begin
        q_item.cmd       = lbp_pkg::cmd_t'(command);
        q_item.width     = bit_width;
        q_item.width_err = (bit_width > lbp_pkg::WIDTH_W'(lbp_pkg::MAX_CODE_BITS));
        q_item.value     = code_value & mask_wide;
    end

endmodule

// File: rtl/lbp_cmd_fifo.sv
// Short command queue between front end and packing engine.
`timescale 1ns / 1ps

module lbp_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  lbp_pkg::cmd_item_t   wr_item,
    output logic                 full,
    input  logic                 rd_en,
    output lbp_pkg::cmd_item_t   rd_item,
    output logic                 q_empty
);

    localparam int PTR_W = (lbp_pkg::QDEPTH > 1) ? $clog2(lbp_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(lbp_pkg::QDEPTH + 1);

    lbp_pkg::cmd_item_t entry_reg [lbp_pkg::QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(lbp_pkg::QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lbp_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lbp_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: rtl/lbp_back.sv
// Packing engine: bit accumulator, byte emission and result register.
`timescale 1ns / 1ps

module lbp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  lbp_pkg::cmd_item_t                  q_item,
    output logic                                q_pop,
    input  logic [lbp_pkg::OFFSET_BITS-1:0]     start_offset,
    input  logic [lbp_pkg::LIMIT_W-1:0]         out_limit,
    input  logic                                pop,
    output logic                                empty,
    output lbp_pkg::result_t                    result
);

    localparam int SUM_W = lbp_pkg::PEND_W + 1;

    lbp_pkg::back_state_t                state_reg, state_next;
    logic [lbp_pkg::ACC_BITS-1:0]        acc_reg, acc_next;
    logic [lbp_pkg::PEND_W-1:0]          pend_reg, pend_next;
    logic [lbp_pkg::LIMIT_W-1:0]         off_reg, off_next;
    logic                                res_valid_reg, res_valid_next;
    lbp_pkg::result_t                    res_reg, res_next;

    logic                                out_free;
    logic                                emit;
    lbp_pkg::result_t                    beat;
    logic [lbp_pkg::ACC_BITS-1:0]        merged;
    logic [SUM_W-1:0]                    pend_sum;
    logic                                acc_over;
    logic [lbp_pkg::LIMIT_W-1:0]         eff_limit;
    logic                                at_limit;
    logic                                put_two;
    logic [7:0]                          flush_mask;

    assign out_free  = !res_valid_reg || pop;
    assign empty     = !res_valid_reg;
    assign result    = res_reg;

    assign merged    = acc_reg | (lbp_pkg::ACC_BITS'(q_item.value) << pend_reg);
    assign pend_sum  = SUM_W'(pend_reg) + SUM_W'(q_item.width);
    assign acc_over  = pend_sum > SUM_W'(lbp_pkg::ACC_BITS);
    assign eff_limit = (out_limit > lbp_pkg::LIMIT_CAP) ? lbp_pkg::LIMIT_CAP : out_limit;
    assign at_limit  = off_reg >= eff_limit;
    assign put_two   = (q_item.cmd == lbp_pkg::CMD_PUT) && !q_item.width_err && !acc_over
                       && (pend_sum >= SUM_W'(16)) && !at_limit;
    // eight pending bits shift the one out, so the mask wraps to all ones
    assign flush_mask = (8'h1 << pend_reg[3:0]) - 8'h1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbp_pkg::ST_IDLE:
            begin
                if (!q_empty && out_free && put_two)
                begin
                    state_next = lbp_pkg::ST_SECOND;
                end
            end
            lbp_pkg::ST_SECOND:
            begin
                if (out_free)
                begin
                    state_next = lbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        acc_next        = acc_reg;
        pend_next       = pend_reg;
        off_next        = off_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        beat.out_byte   = 8'h00;
        beat.out_index  = off_reg[lbp_pkg::OFFSET_BITS-1:0];
        beat.byte_valid = 1'b0;
        beat.error      = 1'b0;
        beat.last       = 1'b1;
        case (state_reg)
            lbp_pkg::ST_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    case (q_item.cmd)
                        lbp_pkg::CMD_PUT:
                        begin
                            if (q_item.width_err || acc_over)
                            begin
                                beat.error = 1'b1;
                            end
                            else if (pend_sum < SUM_W'(8))
                            begin
                                acc_next  = merged;
                                pend_next = pend_sum[lbp_pkg::PEND_W-1:0];
                            end
                            else if (at_limit)
                            begin
                                acc_next   = merged;
                                pend_next  = pend_sum[lbp_pkg::PEND_W-1:0];
                                beat.error = 1'b1;
                            end
                            else
                            begin
                                acc_next        = merged >> 8;
                                pend_next       = pend_sum[lbp_pkg::PEND_W-1:0] - lbp_pkg::PEND_W'(8);
                                off_next        = off_reg + 1'b1;
                                beat.out_byte   = merged[7:0];
                                beat.byte_valid = 1'b1;
                                beat.last       = (pend_sum < SUM_W'(16));
                            end
                        end
                        lbp_pkg::CMD_FLUSH:
                        begin
                            if (pend_reg > lbp_pkg::PEND_W'(8))
                            begin
                                beat.error = 1'b1;
                            end
                            else if (pend_reg != '0)
                            begin
                                if (at_limit)
                                begin
                                    beat.error = 1'b1;
                                end
                                else
                                begin
                                    acc_next        = '0;
                                    pend_next       = '0;
                                    off_next        = off_reg + 1'b1;
                                    beat.out_byte   = acc_reg[7:0] & flush_mask;
                                    beat.byte_valid = 1'b1;
                                end
                            end
                        end
                        lbp_pkg::CMD_RESTART:
                        begin
                            acc_next       = '0;
                            pend_next      = '0;
                            off_next       = lbp_pkg::LIMIT_W'(start_offset);
                            beat.out_index = start_offset;
                        end
                        default:
                        begin
                            beat.error = 1'b1;
                        end
                    endcase
                end
            end
            lbp_pkg::ST_SECOND:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (at_limit)
                    begin
                        beat.error = 1'b1;
                    end
                    else
                    begin
                        acc_next        = acc_reg >> 8;
                        pend_next       = pend_reg - lbp_pkg::PEND_W'(8);
                        off_next        = off_reg + 1'b1;
                        beat.out_byte   = acc_reg[7:0];
                        beat.byte_valid = 1'b1;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (emit)
        begin
            res_next       = beat;
            res_valid_next = 1'b1;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lbp_pkg::ST_IDLE;
            acc_reg       <= '0;
            pend_reg      <= '0;
            off_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            off_reg       <= off_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// File: rtl/lsb_first_bit_packer_unit.sv
// Top level of the LSB-first variable-length bit packer.
// Input beats (put, flush, restart) enter a two-entry command queue and are
// executed by the packing engine, which writes one result beat per cycle into
// an output register while that register is empty or being popped. A put
// gives one result beat, or two when it emits two bytes or emits one byte and
// then hits the byte limit; flush, restart and failed commands give one beat.
// The engine's single result register and its one-byte-per-cycle emission
// set the command rate. The queue keeps accepting until it is full while a
// result waits to be popped. Configuration writes are registered
// (start_offset is used at the next restart) and should be made while idle.
`timescale 1ns / 1ps

module lsb_first_bit_packer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          command,
    input  logic [lbp_pkg::MAX_CODE_BITS-1:0]   code_value,
    input  logic [lbp_pkg::WIDTH_W-1:0]         bit_width,
    output logic                                empty,
    input  logic                                pop,
    output logic [7:0]                          out_byte,
    output logic [lbp_pkg::OFFSET_BITS-1:0]     out_index,
    output logic                                byte_valid,
    output logic                                error,
    output logic                                last,
    input  logic                                cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lbp_pkg::LIMIT_W-1:0]         cfg_data
);

    logic [lbp_pkg::OFFSET_BITS-1:0] start_offset_reg, start_offset_next;
    logic [lbp_pkg::LIMIT_W-1:0]     out_limit_reg, out_limit_next;

    logic                q_push, q_full, q_pop, q_empty;
    lbp_pkg::cmd_item_t  in_item, head_item;
    lbp_pkg::result_t    res;

    always_comb
    begin
        start_offset_next = start_offset_reg;
        out_limit_next    = out_limit_reg;
        if (cfg_we)
        begin
            case (lbp_pkg::cfg_reg_t'(cfg_index))
                lbp_pkg::REG_START_OFFSET:
                begin
                    start_offset_next = cfg_data[lbp_pkg::OFFSET_BITS-1:0];
                end
                lbp_pkg::REG_OUT_LIMIT:
                begin
                    out_limit_next = cfg_data;
                end
                default:
                begin
                    start_offset_next = start_offset_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_offset_reg <= '0;
            out_limit_reg    <= lbp_pkg::LIMIT_RESET;
        end
        else
        begin
            start_offset_reg <= start_offset_next;
            out_limit_reg    <= out_limit_next;
        end
    end

    lbp_front u_front (
        .push       (push),
        .command    (command),
        .code_value (code_value),
        .bit_width  (bit_width),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (in_item)
    );

    lbp_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (in_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_item (head_item),
        .q_empty (q_empty)
    );

    lbp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .start_offset (start_offset_reg),
        .out_limit    (out_limit_reg),
        .pop          (pop),
        .empty        (empty),
        .result       (res)
    );

    assign full       = q_full;
    assign out_byte   = res.out_byte;
    assign out_index  = res.out_index;
    assign byte_valid = res.byte_valid;
    assign error      = res.error;
    assign last       = res.last;

endmodule

// File: rtl/lbp_checker.sv
// Port-level checks for the bit packer, bound to the top level.
`timescale 1ns / 1ps

module lbp_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             empty,
    input  logic                             pop,
    input  logic [7:0]                       out_byte,
    input  logic [lbp_pkg::OFFSET_BITS-1:0]  out_index,
    input  logic                             byte_valid,
    input  logic                             error,
    input  logic                             last
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_index)
                              && $stable(byte_valid) && $stable(error) && $stable(last)))
        else $error("waiting result beat changed");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error) |-> last)
        else $error("error flagged on a non-final beat");

    a_error_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error) |-> !byte_valid)
        else $error("error beat carries a byte");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !byte_valid) |-> (out_byte == 8'h00 && last))
        else $error("status beat with nonzero byte or not final");

endmodule

bind lsb_first_bit_packer_unit lbp_checker u_lbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .out_index  (out_index),
    .byte_valid (byte_valid),
    .error      (error),
    .last       (last)
);
